// ----- hw/rtl/kva_pkg.sv -----
// kva_pkg: shared types and constants for the keyed vote accumulator
// used by kva_cell and keyed_vote_accumulator; no dependencies

package kva_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int ROAD_W  = 10;
  localparam int POS_W   = 17;
  localparam int SEG_W   = 14;
  localparam int KIND_W  = 8;
  localparam int VOTE_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int EIDX_W  = 8;

  // half-km floor: sixteenths shifted down by three
  localparam int SEG_SHIFT = POS_W - SEG_W;

  typedef struct packed {
    logic [ROAD_W-1:0] road;
    logic [POS_W-1:0]  km_sixteenths;
    logic [KIND_W-1:0] kind;
    logic [VOTE_W-1:0] votes;
  } in_beat_t;

  typedef struct packed {
    logic [EIDX_W-1:0]  entry_index;
    logic [TOTAL_W-1:0] total;
    logic               created;
    logic               dropped;
  } out_beat_t;

  // report travelling along the cell chain
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [ROAD_W-1:0]  road;
    logic [SEG_W-1:0]   segment;
    logic [KIND_W-1:0]  kind;
    logic [VOTE_W-1:0]  votes;
    logic [IDX_W-1:0]   idx;
    logic [TOTAL_W-1:0] total;
    logic               created;
  } kva_item_t;

  // low byte of a slot index, zero extended for small tables
  function automatic logic [EIDX_W-1:0] to_entry_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+EIDX_W-1:0] wide;
    wide = {{EIDX_W{1'b0}}, idx};
    return wide[EIDX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/kva_cell.sv -----
// kva_cell: one table slot plus one stage of the report chain
// depends on kva_pkg

module kva_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [kva_pkg::IDX_W-1:0] cell_idx,
  input  kva_pkg::kva_item_t item_in,
  output kva_pkg::kva_item_t item_out,
  output logic               slot_valid
);
  import kva_pkg::*;

  logic               slot_valid_r;
  logic [ROAD_W-1:0]  slot_road_r;
  logic [SEG_W-1:0]   slot_segment_r;
  logic [KIND_W-1:0]  slot_kind_r;
  logic [TOTAL_W-1:0] slot_total_r;
  kva_item_t          item_r;
  kva_item_t          item_nxt;

  logic               key_hit;
  logic               hit;
  logic               claim;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sat_total;

  always_comb begin
    key_hit = slot_valid_r && (slot_road_r == item_in.road)
              && (slot_segment_r == item_in.segment) && (slot_kind_r == item_in.kind);
    sum       = {1'b0, slot_total_r} + {{(TOTAL_W+1-VOTE_W){1'b0}}, item_in.votes};
    sat_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    hit       = 1'b0;
    claim     = 1'b0;
    item_nxt  = item_in;
    if (item_in.valid && !item_in.done) begin
      if (key_hit) begin
        hit              = 1'b1;
        item_nxt.done    = 1'b1;
        item_nxt.idx     = cell_idx;
        item_nxt.total   = sat_total;
        item_nxt.created = 1'b0;
      end else if (!slot_valid_r) begin
        // first free slot: every earlier slot is taken, none matched
        claim            = 1'b1;
        item_nxt.done    = 1'b1;
        item_nxt.idx     = cell_idx;
        item_nxt.total   = {{(TOTAL_W-VOTE_W){1'b0}}, item_in.votes};
        item_nxt.created = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r       <= '0;
      slot_valid_r <= 1'b0;
    end else if (advance) begin
      item_r <= item_nxt;
      if (claim) begin
        slot_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && claim) begin
      slot_road_r    <= item_in.road;
      slot_segment_r <= item_in.segment;
      slot_kind_r    <= item_in.kind;
      slot_total_r   <= {{(TOTAL_W-VOTE_W){1'b0}}, item_in.votes};
    end else if (advance && hit) begin
      slot_total_r <= sat_total;
    end
  end

  assign item_out   = item_r;
  assign slot_valid = slot_valid_r;

endmodule

// ----- hw/rtl/keyed_vote_accumulator.sv -----
// keyed_vote_accumulator: top level, chain of slot cells and output register
// depends on kva_pkg and kva_cell
//
// usage
//   in channel: one alert report per beat (road, km_sixteenths, kind, votes),
//   taken when in_valid is high and in_stall is low
//   out channel: exactly one result beat per report, in report order
//   (entry_index, total, created, dropped)
//   each report walks a row of TABLE_ENTRIES cells, one cell per cycle; a cell
//   holds one slot and either adds the votes on a key match or claims itself
//   when still free. reports that find no slot come out with dropped set
//   result: the beat is registered in the output register after the last cell
//   throughput: one report per cycle while the chain is not stalled;
//   a report sees every update left by the reports ahead of it
//   reset: all slots are marked free and the chain is emptied
//   stall: while a result waits on out_stall the whole chain holds and
//   in_stall is raised; nothing is lost or repeated

module keyed_vote_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kva_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kva_pkg::out_beat_t out_data
);
  import kva_pkg::*;

  kva_item_t               chain [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_valid_vec;
  logic                    advance;
  logic                    out_valid_r;
  out_beat_t               out_data_r;
  out_beat_t               out_data_nxt;

  // the chain moves whenever the output register is free or being emptied
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // incoming beat enters the chain with the position floored to half-km
  always_comb begin
    chain[0]         = '0;
    chain[0].valid   = in_valid;
    chain[0].road    = in_data.road;
    chain[0].segment = in_data.km_sixteenths[POS_W-1:SEG_SHIFT];
    chain[0].kind    = in_data.kind;
    chain[0].votes   = in_data.votes;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    kva_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .cell_idx   (IDX_W'(g)),
      .item_in    (chain[g]),
      .item_out   (chain[g+1]),
      .slot_valid (slot_valid_vec[g])
    );
  end

  // result beat: a report that neither matched nor claimed a slot on the way is dropped
  always_comb begin
    out_data_nxt = '0;
    if (chain[TABLE_ENTRIES].done) begin
      out_data_nxt.entry_index = to_entry_index(chain[TABLE_ENTRIES].idx);
      out_data_nxt.total       = chain[TABLE_ENTRIES].total;
      out_data_nxt.created     = chain[TABLE_ENTRIES].created;
    end else begin
      out_data_nxt.dropped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[TABLE_ENTRIES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // slots are claimed lowest first, so the taken slots form a prefix
  a_slot_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_valid_vec & (slot_valid_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1})) == '0)
    else $error("taken slots are not a prefix");

  // a dropped report only when every slot is taken
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.dropped) |-> (&slot_valid_vec))
    else $error("report dropped with a free slot");

  // no slot is claimed or freed while the chain is held
  a_hold_slots: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(slot_valid_vec))
    else $error("slot claimed while stalled");

  // a dropped beat never claims a slot
  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.dropped && out_data_r.created))
    else $error("result both created and dropped");

endmodule
